// File: rtl/core/raqt_pkg.sv
// shared types and constants for the replica ack quorum tracker
// no dependencies; used by raqt_id_mem and replica_ack_quorum_tracker
package raqt_pkg;

	localparam int unsigned MAX_REPLICAS_DEF = 16;
	localparam int unsigned ID_W             = 256;
	localparam int unsigned WORD_W           = 64;
	localparam int unsigned THR_W            = 5;
	localparam int unsigned ACK_W            = 5;
	localparam int unsigned STAT_W           = 3;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_ACK   = 2'd1,
		CMD_QUERY = 2'd2
	} cmd_t;

	localparam logic [STAT_W-1:0] STAT_OK          = 3'd0;
	localparam logic [STAT_W-1:0] STAT_NONCANON    = 3'd1;
	localparam logic [STAT_W-1:0] STAT_UNKNOWN     = 3'd2;
	localparam logic [STAT_W-1:0] STAT_BELOW_QUORUM = 3'd3;
	localparam logic [STAT_W-1:0] STAT_RECORD_FAIL = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [1:0]        command;
		logic [WORD_W-1:0] id_word0;
		logic [WORD_W-1:0] id_word1;
		logic [WORD_W-1:0] id_word2;
		logic [WORD_W-1:0] id_word3;
		logic              load_last;
		logic              record_ok;
	} item_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic              eligible;
		logic [ACK_W-1:0]  acks_seen;
	} result_t;

endpackage

// File: rtl/core/raqt_id_mem.sv
// two-bank replica id store, one 256-bit id per row, one write and one read port
// registered read data; depends on raqt_pkg
module raqt_id_mem #(
	parameter int unsigned MAX_REPLICAS = raqt_pkg::MAX_REPLICAS_DEF,
	parameter int unsigned SLOT_W       = (MAX_REPLICAS > 1) ? $clog2(MAX_REPLICAS) : 1
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic                      wr_bank,
	input  logic [SLOT_W-1:0]         wr_slot,
	input  logic [raqt_pkg::ID_W-1:0] wr_data,
	input  logic                      rd_en,
	input  logic                      rd_bank,
	input  logic [SLOT_W-1:0]         rd_slot,
	output logic [raqt_pkg::ID_W-1:0] rd_data
);
	import raqt_pkg::*;

	localparam int unsigned DEPTH  = 2 * MAX_REPLICAS;
	localparam int unsigned ADDR_W = $clog2(DEPTH);

	logic [ID_W-1:0]   mem [DEPTH];
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;

	// bank 1 sits above bank 0
	assign wr_addr = ADDR_W'(wr_slot) + (wr_bank ? ADDR_W'(MAX_REPLICAS) : '0);
	assign rd_addr = ADDR_W'(rd_slot) + (rd_bank ? ADDR_W'(MAX_REPLICAS) : '0);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/core/replica_ack_quorum_tracker.sv
// replica ack quorum tracker top level: command sequencer, id scan and quorum state
// depends on raqt_pkg and raqt_id_mem
//
// usage:
//   an item transfers at a rising edge with start high and busy low. the item
//   carries a command (load id, acknowledge, query), a 256-bit id and two flags.
//   every item gives exactly one result: done is high for one cycle with result
//   valid; the receiver cannot stall, so the result must be taken that cycle.
//   cfg_we with cfg_wdata writes the quorum threshold (reset value 1); it is
//   sampled when a load marked last commits the batch. write it only when idle.
//   load and acknowledge scan the stored ids one row per cycle through a single
//   256-bit compare fed by the registered memory read: a load scans the ids
//   loaded so far into the shadow bank, an acknowledge the active batch.
//   an item with ids to scan holds busy through the scan state and the finish
//   step; done and the result register are loaded as it leaves the finish step.
//   a query skips the scan and holds busy only through the finish step.
//   a new item is taken only once busy is low again, so items do not overlap.
//   async reset (arst_n low) clears the batch, counts, ack marks and errors;
//   the id memory is not cleared, only rows that were written are ever read.
module replica_ack_quorum_tracker #(
	parameter int unsigned MAX_REPLICAS = raqt_pkg::MAX_REPLICAS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  raqt_pkg::item_t            item,
	input  logic                       cfg_we,
	input  logic [raqt_pkg::THR_W-1:0] cfg_wdata,
	output logic                       done,
	output raqt_pkg::result_t          result
);
	import raqt_pkg::*;

	localparam int unsigned SLOT_W = (MAX_REPLICAS > 1) ? $clog2(MAX_REPLICAS) : 1;
	localparam int unsigned CNT_W  = $clog2(MAX_REPLICAS + 1);
	localparam int unsigned CMP_W  = (CNT_W > THR_W) ? CNT_W : THR_W;

	state_t             state_q, state_d;
	logic [1:0]         cmd_q;
	logic [ID_W-1:0]    id_q;
	logic               last_q;
	logic               rec_q;
	logic               zero_q;
	logic [CNT_W-1:0]   limit_q;
	logic               bank_q;
	logic [CNT_W-1:0]   idx_q;
	logic               vld_s1;
	logic [SLOT_W-1:0]  slot_s1;
	logic               hit_q;
	logic [SLOT_W-1:0]  hit_slot_q;

	logic [THR_W-1:0]   thr_q;
	logic [THR_W-1:0]   act_thr_q;
	logic               active_bank_q;
	logic               batch_valid_q;
	logic [CNT_W-1:0]   active_count_q;
	logic [CNT_W-1:0]   shadow_count_q;
	logic               load_err_q;
	logic [MAX_REPLICAS-1:0] ack_q;
	logic [CNT_W-1:0]   ack_count_q;

	logic               done_q;
	result_t            result_q;

	logic               accept;
	logic               issue;
	logic               wr_en;
	logic [ID_W-1:0]    rd_data;
	logic               id_eq;

	// finish-step values
	logic               full;
	logic               ld_err;
	logic [CNT_W-1:0]   ld_cnt;
	logic               commit_ok;
	logic               ack_new;
	logic               ack_dup;
	logic               nxt_valid;
	logic [THR_W-1:0]   nxt_thr;
	logic [CNT_W-1:0]   nxt_ack_count;
	logic [STAT_W-1:0]  fin_status;
	logic               fin_elig;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;
	assign issue  = (state_q == ST_SCAN) && (idx_q < limit_q);
	assign id_eq  = (rd_data == id_q);

	assign wr_en = (state_q == ST_FINISH) && (cmd_q == CMD_LOAD) && !full;

	raqt_id_mem #(
		.MAX_REPLICAS (MAX_REPLICAS),
		.SLOT_W       (SLOT_W)
	) u_id_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_bank (!active_bank_q),
		.wr_slot (shadow_count_q[SLOT_W-1:0]),
		.wr_data (id_q),
		.rd_en   (issue),
		.rd_bank (bank_q),
		.rd_slot (idx_q[SLOT_W-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (item.command == CMD_LOAD || item.command == CMD_ACK)
						? ST_SCAN : ST_FINISH;
				end
			end
			ST_SCAN: begin
				// the last pending compare lands in hit_q on the leaving edge
				if (!issue) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// results of the finished scan
	always_comb begin
		full          = (shadow_count_q >= CNT_W'(MAX_REPLICAS));
		ld_err        = load_err_q || zero_q || hit_q || full;
		ld_cnt        = full ? shadow_count_q : shadow_count_q + CNT_W'(1);
		commit_ok     = !ld_err && (thr_q != '0) && (CMP_W'(thr_q) <= CMP_W'(ld_cnt));
		ack_dup       = hit_q && ack_q[hit_slot_q];
		ack_new       = hit_q && !ack_q[hit_slot_q] && rec_q;
		nxt_valid     = batch_valid_q;
		nxt_thr       = act_thr_q;
		nxt_ack_count = ack_count_q;
		fin_status    = STAT_OK;
		case (cmd_q)
			CMD_LOAD: begin
				if (last_q) begin
					if (commit_ok) begin
						nxt_valid     = 1'b1;
						nxt_thr       = thr_q;
						nxt_ack_count = '0;
					end
					fin_status = commit_ok ? STAT_OK : STAT_NONCANON;
				end else begin
					fin_status = ld_err ? STAT_NONCANON : STAT_OK;
				end
			end
			CMD_ACK: begin
				if (!hit_q) begin
					fin_status = STAT_UNKNOWN;
				end else if (ack_dup) begin
					fin_status = STAT_OK;
				end else if (!rec_q) begin
					fin_status = STAT_RECORD_FAIL;
				end else begin
					nxt_ack_count = ack_count_q + CNT_W'(1);
					fin_status    = STAT_OK;
				end
			end
			default: begin
				if (!batch_valid_q) begin
					fin_status = STAT_NONCANON;
				end else if (CMP_W'(ack_count_q) >= CMP_W'(act_thr_q)) begin
					fin_status = STAT_OK;
				end else begin
					fin_status = STAT_BELOW_QUORUM;
				end
			end
		endcase
		fin_elig = nxt_valid && (CMP_W'(nxt_ack_count) >= CMP_W'(nxt_thr));
	end

	// item capture and scan bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			hit_q   <= 1'b0;
			idx_q   <= '0;
			limit_q <= '0;
		end else begin
			vld_s1 <= issue;
			if (accept) begin
				idx_q <= '0;
				hit_q <= 1'b0;
				if (item.command == CMD_LOAD) begin
					limit_q <= shadow_count_q;
				end else begin
					limit_q <= batch_valid_q ? active_count_q : '0;
				end
			end else begin
				if (issue) begin
					idx_q <= idx_q + CNT_W'(1);
				end
				if (vld_s1 && id_eq && !hit_q) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= item.command;
			id_q   <= {item.id_word3, item.id_word2, item.id_word1, item.id_word0};
			last_q <= item.load_last;
			rec_q  <= item.record_ok;
			zero_q <= ({item.id_word3, item.id_word2, item.id_word1, item.id_word0} == '0);
			bank_q <= (item.command == CMD_LOAD) ? !active_bank_q : active_bank_q;
		end
		if (issue) begin
			slot_s1 <= idx_q[SLOT_W-1:0];
		end
		if (!accept && vld_s1 && id_eq && !hit_q) begin
			hit_slot_q <= slot_s1;
		end
		if (state_q == ST_FINISH) begin
			result_q.status    <= fin_status;
			result_q.eligible  <= fin_elig;
			result_q.acks_seen <= ACK_W'(nxt_ack_count);
		end
	end

	// batch and quorum state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q          <= THR_W'(1);
			act_thr_q      <= '0;
			active_bank_q  <= 1'b0;
			batch_valid_q  <= 1'b0;
			active_count_q <= '0;
			shadow_count_q <= '0;
			load_err_q     <= 1'b0;
			ack_q          <= '0;
			ack_count_q    <= '0;
			done_q         <= 1'b0;
		end else begin
			done_q <= (state_q == ST_FINISH);
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (state_q == ST_FINISH) begin
				ack_count_q <= nxt_ack_count;
				if (cmd_q == CMD_LOAD) begin
					if (last_q) begin
						shadow_count_q <= '0;
						load_err_q     <= 1'b0;
						if (commit_ok) begin
							active_bank_q  <= !active_bank_q;
							active_count_q <= ld_cnt;
							act_thr_q      <= thr_q;
							batch_valid_q  <= 1'b1;
							ack_q          <= '0;
						end
					end else begin
						shadow_count_q <= ld_cnt;
						load_err_q     <= ld_err;
					end
				end else if (cmd_q == CMD_ACK && ack_new) begin
					ack_q[hit_slot_q] <= 1'b1;
				end
			end
		end
	end

endmodule

// File: sim/quorum_checker.sv
// result checker for replica_ack_quorum_tracker: tracks the id banks, ack marks and
// threshold from the observed transfers and compares every done strobe against them
// depends on raqt_pkg; instantiated beside the block by testbench
module quorum_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       busy,
	input  raqt_pkg::item_t            item,
	input  logic                       cfg_we,
	input  logic [raqt_pkg::THR_W-1:0] cfg_wdata,
	input  logic                       done,
	input  raqt_pkg::result_t          result,
	output int                         fail_count,
	output int                         pending_results
);
	timeunit 1ns;
	timeprecision 1ps;

	import raqt_pkg::*;

	// two id banks, the shadow one is the bank not active
	bit [ID_W-1:0]             id_bank [2][MAX_REPLICAS_DEF];
	bit                        act_bank;
	bit                        batch_live;
	int                        act_cnt;
	int                        shd_cnt;
	bit                        shd_err;
	bit [MAX_REPLICAS_DEF-1:0] ack_marks;
	int                        ack_total;
	int                        act_thr;
	int                        thr_reg;

	result_t                   expected_q[$];
	result_t                   want;
	int                        fails = 0;
	int                        pending = 0;

	assign fail_count      = fails;
	assign pending_results = pending;

	function automatic result_t apply_command(item_t it);
		bit [ID_W-1:0] idv;
		bit            sb;
		int            slot;
		result_t       r;
		idv      = {it.id_word3, it.id_word2, it.id_word1, it.id_word0};
		sb       = ~act_bank;
		slot     = -1;
		r.status = STAT_OK;
		case (it.command)
			CMD_LOAD: begin
				if (idv == '0)
					shd_err = 1'b1;
				for (int s = 0; s < shd_cnt; s++)
					if (id_bank[sb][s] == idv)
						shd_err = 1'b1;
				// a full shadow bank drops the id
				if (shd_cnt >= MAX_REPLICAS_DEF) begin
					shd_err = 1'b1;
				end else begin
					id_bank[sb][shd_cnt] = idv;
					shd_cnt++;
				end
				if (it.load_last) begin
					if (!shd_err && thr_reg != 0 && thr_reg <= shd_cnt) begin
						act_bank   = sb;
						act_cnt    = shd_cnt;
						act_thr    = thr_reg;
						batch_live = 1'b1;
						ack_marks  = '0;
						ack_total  = 0;
					end else begin
						shd_err = 1'b1;
					end
				end
				r.status = shd_err ? STAT_NONCANON : STAT_OK;
				// commit attempt always reopens the shadow bank
				if (it.load_last) begin
					shd_cnt = 0;
					shd_err = 1'b0;
				end
			end
			CMD_ACK: begin
				if (batch_live)
					for (int s = 0; s < act_cnt; s++)
						if (slot < 0 && id_bank[act_bank][s] == idv)
							slot = s;
				if (slot < 0) begin
					r.status = STAT_UNKNOWN;
				end else if (ack_marks[slot]) begin
					r.status = STAT_OK;
				end else if (!it.record_ok) begin
					r.status = STAT_RECORD_FAIL;
				end else begin
					ack_marks[slot] = 1'b1;
					ack_total++;
				end
			end
			default: begin
				// the unused command code behaves as a query
				if (!batch_live)
					r.status = STAT_NONCANON;
				else
					r.status = (ack_total >= act_thr) ? STAT_OK : STAT_BELOW_QUORUM;
			end
		endcase
		r.eligible  = batch_live && ack_total >= act_thr;
		r.acks_seen = ACK_W'(ack_total);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_bank   = 1'b0;
			batch_live = 1'b0;
			act_cnt    = 0;
			shd_cnt    = 0;
			shd_err    = 1'b0;
			ack_marks  = '0;
			ack_total  = 0;
			act_thr    = 0;
			thr_reg    = 1;
			expected_q.delete();
			pending    = 0;
		end else begin
			// results leave before this edge's transfer is predicted
			if (done) begin
				if (expected_q.size() == 0) begin
					$error("result with no transfer outstanding");
					fails++;
				end else begin
					want = expected_q.pop_front();
					if (result.status !== want.status) begin
						$error("status mismatch: expected %0d, actual %0d",
							want.status, result.status);
						fails++;
					end
					if (result.eligible !== want.eligible) begin
						$error("eligible mismatch: expected %0d, actual %0d",
							want.eligible, result.eligible);
						fails++;
					end
					if (result.acks_seen !== want.acks_seen) begin
						$error("acks_seen mismatch: expected %0d, actual %0d",
							want.acks_seen, result.acks_seen);
						fails++;
					end
				end
			end
			if (cfg_we)
				thr_reg = cfg_wdata;
			if (start && !busy)
				expected_q.push_back(apply_command(item));
			pending = expected_q.size();
		end
	end

endmodule

// File: sim/testbench.sv
// stimulus and verdict for replica_ack_quorum_tracker: directed corner items, then
// phases of load batches, acknowledgements and queries under several thresholds
// depends on raqt_pkg, the block and quorum_checker
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import raqt_pkg::*;

	localparam logic [1:0]      CMD_SPARE       = 2'd3;
	localparam int              ITEMS_PER_PHASE = 180;
	localparam logic [ID_W-1:0] ID_ZERO         = '0;
	localparam logic [ID_W-1:0] ID_ONES         = '1;

	typedef enum {FLAW_NONE, FLAW_ZERO, FLAW_DUP} flaw_t;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	item_t            item;
	logic             cfg_we;
	logic [THR_W-1:0] cfg_wdata;
	logic             done;
	result_t          result;
	int               fail_count;
	int               pending_results;

	int               gap_pct = 0;
	int               items_sent = 0;
	int               cur_thr = 1;
	int               shadow_left = 0;
	logic [ID_W-1:0]  batch_ids[$];

	replica_ack_quorum_tracker u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.result    (result)
	);

	quorum_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.item            (item),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.done            (done),
		.result          (result),
		.fail_count      (fail_count),
		.pending_results (pending_results)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// mix of fully random ids and sparse patterns that stress the wide compare
	function automatic logic [ID_W-1:0] rand_id();
		logic [ID_W-1:0] v;
		v = '0;
		case ($urandom_range(0, 9))
			0: v = ID_ONES;
			1: v = ID_W'(1) << $urandom_range(0, ID_W - 1);
			2: v[$urandom_range(0, 3) * WORD_W +: WORD_W] = {$urandom, $urandom} | 64'd1;
			default: begin
				for (int k = 0; k < ID_W / 32; k++)
					v[k * 32 +: 32] = $urandom;
			end
		endcase
		return v;
	endfunction

	// one transfer; start stays high when the next item follows without a gap
	task automatic send(input logic [1:0] cmd, input logic [ID_W-1:0] id,
			input logic last, input logic rec);
		item_t it;
		it.command   = cmd;
		it.id_word0  = id[63:0];
		it.id_word1  = id[127:64];
		it.id_word2  = id[191:128];
		it.id_word3  = id[255:192];
		it.load_last = last;
		it.record_ok = rec;
		while ($urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		item  <= it;
		while (busy)
			@(negedge clk);
		@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic write_threshold(input logic [THR_W-1:0] v);
		start <= 1'b0;
		@(negedge clk);
		while (pending_results != 0 || busy)
			@(negedge clk);
		repeat (3) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		cur_thr = v;
	endtask

	task automatic load_sequence(input int n, input flaw_t flaw, input bit close);
		logic [ID_W-1:0] ids[$];
		logic [ID_W-1:0] id;
		bit              fresh;
		int              pos;
		repeat (n) begin
			do begin
				id    = rand_id();
				fresh = 1'b1;
				foreach (ids[k])
					if (ids[k] == id)
						fresh = 1'b0;
			end while (!fresh);
			ids.push_back(id);
		end
		pos = $urandom_range(1, n - 1);
		if (flaw == FLAW_ZERO)
			ids[$urandom_range(0, n - 1)] = ID_ZERO;
		else if (flaw == FLAW_DUP)
			ids[pos] = ids[$urandom_range(0, pos - 1)];
		foreach (ids[k])
			send(CMD_LOAD, ids[k], close && k == n - 1, 1'($urandom));
		// remember the batch only when it should have committed
		if (flaw == FLAW_NONE && close && shadow_left == 0 && n <= MAX_REPLICAS_DEF &&
				cur_thr >= 1 && cur_thr <= n)
			batch_ids = ids;
		shadow_left = close ? 0 : shadow_left + n;
	endtask

	task automatic ack_round(input int m);
		int              r;
		logic [ID_W-1:0] id;
		repeat (m) begin
			r  = $urandom_range(0, 99);
			id = (batch_ids.size() > 0) ?
				batch_ids[$urandom_range(0, batch_ids.size() - 1)] : rand_id();
			if (r < 8)
				send(CMD_QUERY, rand_id(), 1'($urandom), 1'($urandom));
			else if (r < 11)
				send(CMD_SPARE, rand_id(), 1'($urandom), 1'($urandom));
			else if (r < 15)
				send(CMD_ACK, rand_id(), 1'($urandom), 1'($urandom));
			else if (r < 19)
				send(CMD_ACK, id ^ (ID_W'(1) << $urandom_range(0, ID_W - 1)),
					1'($urandom), 1'b1);
			else
				send(CMD_ACK, id, 1'($urandom), $urandom_range(0, 99) < 80);
		end
	endtask

	task automatic noise_burst();
		int              r;
		logic [ID_W-1:0] id;
		repeat ($urandom_range(1, 6)) begin
			r = $urandom_range(0, 9);
			if (r == 0)
				id = ID_ZERO;
			else if (r < 5 && batch_ids.size() > 0)
				id = batch_ids[$urandom_range(0, batch_ids.size() - 1)];
			else
				id = rand_id();
			send(2'($urandom_range(0, 3)), id, $urandom_range(0, 99) < 30, 1'($urandom));
		end
	endtask

	task automatic run_phase(input logic [THR_W-1:0] thr, input int pct);
		int first;
		int kind;
		int lo;
		int hi;
		int n;
		write_threshold(thr);
		gap_pct = pct;
		first   = items_sent;
		lo      = (thr >= 1 && thr <= MAX_REPLICAS_DEF) ? int'(thr) : 1;
		hi      = (lo + 3 > MAX_REPLICAS_DEF) ? MAX_REPLICAS_DEF : lo + 3;
		while (items_sent - first < ITEMS_PER_PHASE) begin
			kind = $urandom_range(0, 99);
			if (kind < 65) begin
				n = ($urandom_range(0, 9) == 0) ? MAX_REPLICAS_DEF : $urandom_range(lo, hi);
				load_sequence(n, FLAW_NONE, 1'b1);
				ack_round($urandom_range(n, 2 * n + 2));
			end else if (kind < 72) begin
				load_sequence($urandom_range(2, 6), FLAW_ZERO, 1'b1);
				ack_round(3);
			end else if (kind < 80) begin
				load_sequence($urandom_range(2, 6), FLAW_DUP, 1'b1);
				ack_round(3);
			end else if (kind < 85) begin
				// more ids than the shadow bank holds
				load_sequence($urandom_range(MAX_REPLICAS_DEF + 1, MAX_REPLICAS_DEF + 3),
					FLAW_NONE, 1'b1);
				ack_round(3);
			end else if (kind < 87) begin
				load_sequence($urandom_range(1, 3), FLAW_NONE, 1'b0);
			end else begin
				noise_burst();
			end
		end
	endtask

	initial begin
		logic [ID_W-1:0] id_b;
		logic [ID_W-1:0] id_c;
		arst_n    = 1'b0;
		start     = 1'b0;
		item      = '0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		id_b = rand_id();
		id_c = ID_W'(1);
		// nothing loaded yet
		send(CMD_QUERY, rand_id(), 1'b1, 1'b1);
		send(CMD_ACK, ID_ONES, 1'b0, 1'b1);
		send(CMD_SPARE, ID_ZERO, 1'b0, 1'b0);
		// single id batch under the reset threshold
		send(CMD_LOAD, ID_ONES, 1'b1, 1'b0);
		send(CMD_ACK, ID_ONES, 1'b0, 1'b0);
		send(CMD_ACK, ID_ONES, 1'b1, 1'b1);
		send(CMD_ACK, ID_ONES, 1'b0, 1'b0);
		send(CMD_ACK, ID_ONES ^ (ID_W'(1) << (ID_W - 1)), 1'b0, 1'b1);
		send(CMD_QUERY, ID_ONES, 1'b0, 1'b0);
		// zero id poisons the sequence, the active batch survives
		send(CMD_LOAD, ID_ZERO, 1'b0, 1'b1);
		send(CMD_LOAD, id_b, 1'b1, 1'b0);
		send(CMD_ACK, ID_ONES, 1'b0, 1'b1);
		// repeated id
		send(CMD_LOAD, id_b, 1'b0, 1'b1);
		send(CMD_LOAD, id_b, 1'b1, 1'b1);
		// good commit clears the acks
		send(CMD_LOAD, id_c, 1'b1, 1'b1);
		send(CMD_QUERY, ID_ZERO, 1'b1, 1'b0);
		send(CMD_ACK, id_c, 1'b1, 1'b1);
		send(CMD_SPARE, ID_ONES, 1'b1, 1'b1);
		batch_ids.delete();
		batch_ids.push_back(id_c);

		run_phase(5'd16, 0);
		run_phase(5'd0, 79);
		run_phase(5'd3, 0);
		run_phase(5'd31, 37);
		run_phase(5'd1, 0);
		run_phase(THR_W'($urandom_range(2, 16)), 79);
		run_phase(5'd16, 0);
		run_phase(THR_W'($urandom_range(1, 4)), 37);

		start <= 1'b0;
		while (pending_results != 0)
			@(negedge clk);
		repeat (25) @(negedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
